/* src/nch_pkg.sv */
// Shared definitions for the noise channel: operation codes, register
// addresses and the period and length lookup tables. No dependencies.
package nch_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned ADDR_W   = 2;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned SAMPLE_W = 4;
  localparam int unsigned LFSR_W   = 15;
  localparam int unsigned PERIOD_W = 12;
  localparam int unsigned LENGTH_W = 8;
  localparam int unsigned LEVEL_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 3'd0,
    OP_READ     = 3'd1,
    OP_PERIOD   = 3'd2,
    OP_LENGTH   = 3'd3,
    OP_ENVELOPE = 3'd4
  } nch_op_t;

  localparam logic [ADDR_W-1:0] REG_CTRL   = 2'd0;
  localparam logic [ADDR_W-1:0] REG_UNUSED = 2'd1;
  localparam logic [ADDR_W-1:0] REG_PERIOD = 2'd2;
  localparam logic [ADDR_W-1:0] REG_LENGTH = 2'd3;

  localparam logic [PERIOD_W-1:0] PERIOD_TABLE [16] = '{
    12'd4,   12'd8,   12'd16,  12'd32,  12'd64,  12'd96,   12'd128,  12'd160,
    12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068
  };

  localparam logic [LENGTH_W-1:0] LENGTH_RELOAD [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

endpackage

/* src/noise_channel_lfsr_envelope.sv */
// Noise channel top level: input register, channel state update and
// result register. Depends on nch_pkg.
//
// Noise channel of a sound chip. Each request on the input stream is one
// operation, carried in in_tuser: a bus write, a bus read, a period tick,
// a length tick or an envelope tick; in_tdata carries the register index
// and the byte to write. Every request yields exactly one result holding
// the readback byte (zero unless the request was a read) and the 4-bit
// output sample after the step. A request is taken into an input register,
// then updates the channel state and fills the result register, so one
// request is accepted every clock while the result register is free;
// out_tvalid is the valid bit of the result register. The only limit on
// rate is the state update loop, and the stream stalls only while the
// result register is held by out_tready low. A write to register 3
// reloads the length counter from its table and arms the envelope restart,
// which the next envelope tick consumes by loading level 15.
module noise_channel_lfsr_envelope (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // [1:0] reg_addr, [9:2] write_data, [15:10] zero
  input  logic [15:0]             in_tdata,
  // [2:0] op
  input  logic [nch_pkg::OP_W-1:0] in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [7:0] read_data, [11:8] sample, [15:12] zero
  output logic [15:0]             out_tdata
);
  import nch_pkg::*;

  // input register
  logic              s1_valid_r;
  nch_op_t           s1_op_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;

  // result register
  logic                out_valid_r;
  logic [DATA_W-1:0]   rd_r, rd_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;

  // channel state
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic [PERIOD_W-1:0] period_count_r, period_count_nxt;
  logic [LENGTH_W-1:0] length_count_r, length_count_nxt;
  logic [LEVEL_W-1:0]  env_level_r, env_level_nxt;
  logic                env_restart_r, env_restart_nxt;
  logic                loop_flag_r, loop_flag_nxt;
  logic                const_vol_r, const_vol_nxt;
  logic [LEVEL_W-1:0]  volume_r, volume_nxt;
  logic                short_mode_r, short_mode_nxt;
  logic [3:0]          period_idx_r, period_idx_nxt;
  logic [4:0]          length_idx_r, length_idx_nxt;

  logic out_free;
  logic s1_fire;
  logic tap;

  // the result register frees when empty or being taken this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, sample_r, rd_r};

  assign tap = short_mode_r ? lfsr_r[6] : lfsr_r[1];

  always_comb begin
    lfsr_nxt         = lfsr_r;
    period_count_nxt = period_count_r;
    length_count_nxt = length_count_r;
    env_level_nxt    = env_level_r;
    env_restart_nxt  = env_restart_r;
    loop_flag_nxt    = loop_flag_r;
    const_vol_nxt    = const_vol_r;
    volume_nxt       = volume_r;
    short_mode_nxt   = short_mode_r;
    period_idx_nxt   = period_idx_r;
    length_idx_nxt   = length_idx_r;
    rd_nxt           = '0;

    case (s1_op_r)
      OP_WRITE: begin
        case (s1_addr_r)
          REG_CTRL: begin
            loop_flag_nxt = s1_data_r[5];
            const_vol_nxt = s1_data_r[4];
            volume_nxt    = s1_data_r[3:0];
          end
          REG_PERIOD: begin
            short_mode_nxt = s1_data_r[7];
            period_idx_nxt = s1_data_r[3:0];
          end
          REG_LENGTH: begin
            length_idx_nxt   = s1_data_r[7:3];
            length_count_nxt = LENGTH_RELOAD[s1_data_r[7:3]];
            env_restart_nxt  = 1'b1;
          end
          default: begin
            // unused register: drop the write
          end
        endcase
      end
      OP_READ: begin
        case (s1_addr_r)
          REG_CTRL:   rd_nxt = {2'b00, loop_flag_r, const_vol_r,
                                const_vol_r ? volume_r : env_level_r};
          REG_PERIOD: rd_nxt = {short_mode_r, 3'b000, period_idx_r};
          REG_LENGTH: rd_nxt = {length_idx_r, 3'b000};
          default:    rd_nxt = '0;
        endcase
      end
      OP_PERIOD: begin
        if (period_count_r == '0) begin
          // shift right, feedback into the top bit, reload the timer
          lfsr_nxt         = {lfsr_r[0] ^ tap, lfsr_r[LFSR_W-1:1]};
          period_count_nxt = PERIOD_TABLE[period_idx_r];
        end else begin
          period_count_nxt = period_count_r - PERIOD_W'(1);
        end
      end
      OP_LENGTH: begin
        if (!loop_flag_r && length_count_r != '0) begin
          length_count_nxt = length_count_r - LENGTH_W'(1);
        end
      end
      OP_ENVELOPE: begin
        if (env_restart_r) begin
          env_level_nxt   = '1;
          env_restart_nxt = 1'b0;
        end else if (env_level_r != '0) begin
          env_level_nxt = env_level_r - LEVEL_W'(1);
        end else if (loop_flag_r) begin
          env_level_nxt = '1;
        end
      end
      default: begin
        // unknown operation: hold everything
      end
    endcase

    // silent while the length counter is spent or the noise bit is set
    if (length_count_nxt == '0 || lfsr_nxt[0]) begin
      sample_nxt = '0;
    end else begin
      sample_nxt = const_vol_nxt ? volume_nxt : env_level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= nch_op_t'(in_tuser);
      s1_addr_r <= in_tdata[ADDR_W-1:0];
      s1_data_r <= in_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rd_r     <= rd_nxt;
      sample_r <= sample_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r         <= LFSR_W'(1);
      period_count_r <= '0;
      length_count_r <= '0;
      env_level_r    <= '0;
      env_restart_r  <= 1'b0;
      loop_flag_r    <= 1'b0;
      const_vol_r    <= 1'b0;
      volume_r       <= '0;
      short_mode_r   <= 1'b0;
      period_idx_r   <= '0;
      length_idx_r   <= '0;
    end else if (s1_fire) begin
      lfsr_r         <= lfsr_nxt;
      period_count_r <= period_count_nxt;
      length_count_r <= length_count_nxt;
      env_level_r    <= env_level_nxt;
      env_restart_r  <= env_restart_nxt;
      loop_flag_r    <= loop_flag_nxt;
      const_vol_r    <= const_vol_nxt;
      volume_r       <= volume_nxt;
      short_mode_r   <= short_mode_nxt;
      period_idx_r   <= period_idx_nxt;
      length_idx_r   <= length_idx_nxt;
    end
  end

endmodule

/* tb/noise_channel_check.sv */
// Watches both streams of the noise channel, predicts each result from its
// request and compares. Depends on nch_pkg for op codes, register indexes and tables.
`timescale 1ns / 100ps
module noise_channel_check (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [15:0]              in_tdata,
  input  logic [nch_pkg::OP_W-1:0] in_tuser,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [15:0]              out_tdata,
  output int                       fail_count,
  output int                       pending
);
  import nch_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic [SAMPLE_W-1:0] sample;
  } noise_result_t;

  // Predicted channel state
  logic [LFSR_W-1:0]   shift_reg;
  logic [PERIOD_W-1:0] timer;
  logic [LENGTH_W-1:0] len_left;
  logic [LEVEL_W-1:0]  env_level;
  logic                env_restart;
  logic                loop_on;
  logic                const_vol;
  logic [LEVEL_W-1:0]  vol;
  logic                short_on;
  logic [3:0]          per_sel;
  logic [4:0]          len_sel;

  noise_result_t sample_q[$];

  task automatic apply_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data, output noise_result_t res);
    logic fb;
    res.read_data = '0;
    case (op)
      OP_WRITE: begin
        case (addr)
          REG_CTRL: begin
            loop_on   = data[5];
            const_vol = data[4];
            vol       = data[3:0];
          end
          REG_PERIOD: begin
            short_on = data[7];
            per_sel  = data[3:0];
          end
          REG_LENGTH: begin
            len_sel     = data[7:3];
            len_left    = LENGTH_RELOAD[data[7:3]];
            env_restart = 1'b1;
          end
          default: ;
        endcase
      end
      OP_READ: begin
        case (addr)
          REG_CTRL:   res.read_data = {2'b00, loop_on, const_vol, const_vol ? vol : env_level};
          REG_PERIOD: res.read_data = {short_on, 3'b000, per_sel};
          REG_LENGTH: res.read_data = {len_sel, 3'b000};
          default:    res.read_data = '0;
        endcase
      end
      OP_PERIOD: begin
        if (timer == '0) begin
          fb        = shift_reg[0] ^ (short_on ? shift_reg[6] : shift_reg[1]);
          shift_reg = {fb, shift_reg[LFSR_W-1:1]};
          timer     = PERIOD_TABLE[per_sel];
        end else begin
          timer = timer - PERIOD_W'(1);
        end
      end
      OP_LENGTH: begin
        if (!loop_on && len_left != '0) len_left = len_left - LENGTH_W'(1);
      end
      OP_ENVELOPE: begin
        if (env_restart) begin
          env_level   = 4'd15;
          env_restart = 1'b0;
        end else if (env_level != '0) begin
          env_level = env_level - LEVEL_W'(1);
        end else if (loop_on) begin
          env_level = 4'd15;
        end
      end
      default: ;
    endcase
    res.sample = (len_left == '0 || shift_reg[0]) ? 4'd0 : (const_vol ? vol : env_level);
  endtask

  always @(posedge clk) begin : watch
    noise_result_t got;
    noise_result_t want;
    if (!rst_n) begin
      shift_reg   = 15'd1;
      timer       = '0;
      len_left    = '0;
      env_level   = '0;
      env_restart = 1'b0;
      loop_on     = 1'b0;
      const_vol   = 1'b0;
      vol         = '0;
      short_on    = 1'b0;
      per_sel     = '0;
      len_sel     = '0;
      sample_q.delete();
      fail_count  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.read_data = out_tdata[7:0];
        got.sample    = out_tdata[11:8];
        if (sample_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result, expected none, got %04h", $time, out_tdata);
        end else begin
          want = sample_q.pop_front();
          if (got.read_data !== want.read_data) begin
            fail_count++;
            $display("%0t ns: read_data expected %02h, got %02h",
                     $time, want.read_data, got.read_data);
          end
          if (got.sample !== want.sample) begin
            fail_count++;
            $display("%0t ns: sample expected %0h, got %0h", $time, want.sample, got.sample);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        apply_request(in_tuser, in_tdata[1:0], in_tdata[9:2], want);
        sample_q.push_back(want);
      end
    end
    pending = sample_q.size();
  end

endmodule

/* tb/noise_channel_lfsr_envelope_test.sv */
// Top of the noise channel testbench: clock, reset, request stimulus and
// verdict. Depends on nch_pkg, the block and noise_channel_check.
`timescale 1ns / 100ps
module noise_channel_lfsr_envelope_test;
  import nch_pkg::*;

  localparam int RANDOM_REQUESTS = 1600;
  // Allow well beyond what the slowest correct run needs
  localparam int CYCLE_LIMIT     = 200000;
  // Edges to wait after the last result is taken, to watch for strays
  localparam int DRAIN_CYCLES    = 12;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata   = '0;
  logic [OP_W-1:0]   in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  // Set during a long stretch of random requests in which neither side idles
  logic calm        = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  noise_channel_lfsr_envelope dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  noise_channel_check sample_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stall the result stream about a quarter of the time, never while calm
  always @(negedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 24);
    end
  end

  // Offer one request from a falling edge and hold it until accepted at a
  // rising edge; may idle first. Returns at the falling edge after acceptance.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    // [1:0] reg_addr, [9:2] write_data, [15:10] zero
    in_tdata  <= {6'd0, data, addr};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    int                pick;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Read every register straight out of reset, the unused one included
    send_request(OP_READ, REG_CTRL, 8'h00);
    send_request(OP_READ, REG_UNUSED, 8'h00);
    send_request(OP_READ, REG_PERIOD, 8'h00);
    send_request(OP_READ, REG_LENGTH, 8'h00);
    // Loop, fixed volume at full level; short mode, fastest period; highest length index
    send_request(OP_WRITE, REG_CTRL, 8'hFF);
    send_request(OP_WRITE, REG_PERIOD, 8'h80);
    send_request(OP_WRITE, REG_LENGTH, 8'hF8);
    // Unused register ignores writes and reads back zero
    send_request(OP_WRITE, REG_UNUSED, 8'hFF);
    send_request(OP_READ, REG_UNUSED, 8'h00);
    send_request(OP_READ, REG_CTRL, 8'h00);
    send_request(OP_READ, REG_PERIOD, 8'h00);
    send_request(OP_READ, REG_LENGTH, 8'h00);
    // Step the timer through two reloads and the counts between them
    repeat (6) send_request(OP_PERIOD, 2'd0, 8'h00);
    // Loop halts the length count
    send_request(OP_LENGTH, 2'd0, 8'h00);
    // Envelope restart loads full level, then decay with volume from the envelope
    send_request(OP_ENVELOPE, 2'd0, 8'h00);
    send_request(OP_WRITE, REG_CTRL, 8'h00);
    send_request(OP_ENVELOPE, 2'd0, 8'h00);
    send_request(OP_READ, REG_CTRL, 8'h00);
    // Unknown ops change nothing and read back zero
    send_request(3'd5, 2'd3, 8'hFF);
    send_request(3'd6, 2'd0, 8'h00);
    send_request(3'd7, 2'd2, 8'hAA);
    // Long mode, slowest period
    send_request(OP_WRITE, REG_PERIOD, 8'h0F);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      calm <= (i >= 600 && i < 900);
      pick = $urandom_range(0, 99);
      addr = ADDR_W'($urandom_range(0, 3));
      data = DATA_W'($urandom_range(0, 255));
      if (pick < 20) begin
        op = OP_WRITE;
        // Keep the period short mostly, so the shift register moves often
        if (addr == REG_PERIOD && $urandom_range(0, 9) < 8) data[3:0] = 4'($urandom_range(0, 3));
      end else if (pick < 35) begin
        op = OP_READ;
      end else if (pick < 70) begin
        op = OP_PERIOD;
      end else if (pick < 82) begin
        op = OP_LENGTH;
      end else if (pick < 94) begin
        op = OP_ENVELOPE;
      end else begin
        op = OP_W'($urandom_range(5, 7));
      end
      send_request(op, addr, data);
    end
    in_tvalid <= 1'b0;
    calm      <= 1'b0;

    // Drain outstanding results, then watch for strays
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
